/* src/mrp_pkg.sv */
// ----------------------------------------------------------------------------
// Masked RGB PSNR package
// Shared widths, constants and the sequencer state type for the PSNR core.
// ----------------------------------------------------------------------------
package mrp_pkg;

   // Channel and accumulator widths.
   localparam int CHAN_W  = 8;
   localparam int ERR_W   = 40;
   localparam int CNT_W   = 23;
   localparam int PSNR_W  = 16;

   // Shared multiplier operand and product widths.
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;

   // Pixel count saturates at this value.
   localparam logic [CNT_W-1:0] MAX_PIXELS = 23'd4194304;

   // Three times the squared peak value, 3*255*255.
   localparam logic [17:0] PEAK_SQ_X3 = 18'd195075;

   // Logarithm format: 6 integer bits (leading-one position) and 24 fraction bits.
   localparam int FRAC_BITS = 24;
   localparam int EXP_W     = 6;
   localparam int LOG_W     = EXP_W + FRAC_BITS;
   localparam int BIT_CNT_W = 5;
   localparam logic [EXP_W-1:0] TOP_BIT = 6'd39;

   // Scale factor 2560*log10(2) in Q28, split into two 19-bit halves so that each
   // partial product fits the shared multiplier.
   localparam int K_HALF_W = 19;
   localparam logic [37:0] K_Q28 = 38'd206866237839;
   localparam logic [K_HALF_W-1:0] K_LO = K_Q28[18:0];
   localparam logic [K_HALF_W-1:0] K_HI = K_Q28[37:19];

   // Scaled sum width and rounding term: result = floor((L*K + 2^51) / 2^52).
   localparam int SUM_W   = 69;
   localparam int PART_W  = LOG_W + K_HALF_W;
   localparam int ACC_W   = 52;
   localparam int Q_LSB   = 52;
   localparam logic [ACC_W-1:0] ROUND_TERM = 52'h8_0000_0000_0000;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CHECK,
      ST_NUM,
      ST_LOAD,
      ST_NORM,
      ST_LOG_MUL,
      ST_LOG_UPD,
      ST_COMPARE,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_SCALE_SUM,
      ST_EMIT
   } state_type;

endpackage

/* src/mrp_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module mrp_mul
   import mrp_pkg::*;
(
   input  logic              clock,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] product
);

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   // The product is registered and appears in the cycle after the operands are presented.
   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

/* src/masked_rgb_psnr_core.sv */
// ----------------------------------------------------------------------------
// Masked RGB PSNR core
// Accumulates squared RGB differences of a pixel stream and reports the PSNR
// of each frame in Q8.8 dB, all multiplications on one shared multiplier.
// ----------------------------------------------------------------------------
// The core takes a pixel only while idle; a used pixel then holds it while its three
// channel squares go through the shared multiplier, a masked one does not. A flagged
// last pixel, once squared if used, goes straight to its result; any other last pixel
// first takes two base-2 logarithms, each a leading-one shift search and 24 squaring
// steps, then a compare and, above a unit ratio, the low, high and sum scaling steps.
// Results wait in an output register, loaded before a new pixel is taken. Reset
// (synchronous, active high) clears the frame state and mask_enable.
module masked_rgb_psnr_core
   import mrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   // Configuration write channel.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata,      // mask_enable

   // Pixel pair stream.
   input  logic              req_tvalid,
   output logic              req_tready,
   // first_red, first_green, first_blue, second_red, second_green, second_blue
   input  logic [47:0]       req_tdata,
   input  logic              req_tuser,      // pixel_valid
   input  logic              req_tlast,      // last_pixel

   // Result stream.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,      // psnr_db_q8
   output logic [1:0]        rsp_tuser       // perfect_match, no_valid_pixels
);

   state_type state_ff, state_in;

   logic                  mask_enable_ff, mask_enable_in;
   logic [CHAN_W-1:0]     diff_ff [3];
   logic [CHAN_W-1:0]     diff_in [3];
   logic                  last_ff, last_in;
   logic [1:0]            chan_ff, chan_in;
   logic [ERR_W-1:0]      error_sum_ff, error_sum_in;
   logic [CNT_W-1:0]      pixel_count_ff, pixel_count_in;
   logic                  seen_valid_ff, seen_valid_in;
   logic                  pass_ff, pass_in;
   logic [ERR_W-1:0]      x_ff, x_in;
   logic [EXP_W-1:0]      shift_ff, shift_in;
   logic [MUL_W-1:0]      m_ff, m_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [BIT_CNT_W-1:0]  bit_ff, bit_in;
   logic [LOG_W-1:0]      la_ff, la_in;
   logic [LOG_W-1:0]      l_ff, l_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [PSNR_W-1:0]     res_psnr_ff, res_psnr_in;
   logic                  res_perfect_ff, res_perfect_in;
   logic                  res_none_ff, res_none_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [PSNR_W-1:0]     rsp_psnr_ff, rsp_psnr_in;
   logic [1:0]            rsp_flags_ff, rsp_flags_in;

   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [PROD_W-1:0]     product;

   logic                  req_fire;
   logic                  emit_load;
   logic                  req_used;
   logic [CHAN_W-1:0]     cur_diff;
   logic [ERR_W:0]        err_add;
   logic [MUL_W:0]        sq_top;
   logic                  frac_bit;
   logic [FRAC_BITS-1:0]  frac_next;
   logic [EXP_W-1:0]      exp_cur;
   logic [LOG_W-1:0]      lb;
   logic [SUM_W-1:0]      scaled_sum;
   logic [PSNR_W:0]       q_raw;

   mrp_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   // Handshakes.
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_used   = !mask_enable_ff || req_tuser;
   assign emit_load  = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   // Helpers shared by the sequencer and the datapath.
   assign exp_cur = TOP_BIT - shift_ff;
   assign lb      = {exp_cur, frac_ff};

   always_comb begin
      unique case (chan_ff)
         2'd0:    cur_diff = diff_ff[0];
         2'd1:    cur_diff = diff_ff[1];
         2'd2:    cur_diff = diff_ff[2];
         default: cur_diff = '0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_used) begin
                  state_in = ST_SQUARE;
               end else if (req_tlast) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_SQUARE: begin
            if (chan_ff == 2'd3) begin
               state_in = last_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (!seen_valid_ff || (error_sum_ff == '0)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_NUM;
            end
         end
         ST_NUM:     state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_NORM;
         ST_NORM: begin
            if (x_ff[ERR_W-1]) begin
               state_in = ST_LOG_MUL;
            end
         end
         ST_LOG_MUL: state_in = ST_LOG_UPD;
         ST_LOG_UPD: begin
            if (bit_ff == BIT_CNT_W'(FRAC_BITS - 1)) begin
               state_in = pass_ff ? ST_COMPARE : ST_LOAD;
            end else begin
               state_in = ST_LOG_MUL;
            end
         end
         ST_COMPARE: state_in = (la_ff <= lb) ? ST_EMIT : ST_SCALE_LO;
         ST_SCALE_LO:  state_in = ST_SCALE_HI;
         ST_SCALE_HI:  state_in = ST_SCALE_SUM;
         ST_SCALE_SUM: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      mask_enable_in = mask_enable_ff;
      diff_in        = diff_ff;
      last_in        = last_ff;
      chan_in        = chan_ff;
      error_sum_in   = error_sum_ff;
      pixel_count_in = pixel_count_ff;
      seen_valid_in  = seen_valid_ff;
      pass_in        = pass_ff;
      x_in           = x_ff;
      shift_in       = shift_ff;
      m_in           = m_ff;
      frac_in        = frac_ff;
      bit_in         = bit_ff;
      la_in          = la_ff;
      l_in           = l_ff;
      acc_in         = acc_ff;
      res_psnr_in    = res_psnr_ff;
      res_perfect_in = res_perfect_ff;
      res_none_in    = res_none_ff;
      rsp_psnr_in    = rsp_psnr_ff;
      rsp_flags_in   = rsp_flags_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      mul_a          = '0;
      mul_b          = '0;

      // Squaring step result: keep 33 bits of m*m / 2^31 and renormalize.
      sq_top    = product[PROD_W-1:MUL_W-1];
      frac_bit  = sq_top[MUL_W];
      frac_next = {frac_ff[FRAC_BITS-2:0], frac_bit};

      // Saturating error accumulation of one channel square.
      err_add = {1'b0, error_sum_ff} + (ERR_W+1)'(product[2*CHAN_W:0]);

      // Scaled logarithm ratio with rounding folded into the accumulator.
      scaled_sum = SUM_W'({product[PART_W-1:0], K_HALF_W'(0)}) + SUM_W'(acc_ff);
      q_raw      = scaled_sum[SUM_W-1:Q_LSB];

      if (csr_valid && csr_ready) begin
         mask_enable_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               for (int c = 0; c < 3; c++) begin
                  if (req_tdata[c*CHAN_W +: CHAN_W] >= req_tdata[(c+3)*CHAN_W +: CHAN_W]) begin
                     diff_in[c] = req_tdata[c*CHAN_W +: CHAN_W]
                                - req_tdata[(c+3)*CHAN_W +: CHAN_W];
                  end else begin
                     diff_in[c] = req_tdata[(c+3)*CHAN_W +: CHAN_W]
                                - req_tdata[c*CHAN_W +: CHAN_W];
                  end
               end
               last_in       = req_tlast;
               chan_in       = '0;
               seen_valid_in = seen_valid_ff || req_used;
               if (pixel_count_ff < MAX_PIXELS) begin
                  pixel_count_in = pixel_count_ff + 1'b1;
               end
            end
         end
         ST_SQUARE: begin
            // Issue one channel square per cycle, accumulate the one before it.
            mul_a   = MUL_W'(cur_diff);
            mul_b   = MUL_W'(cur_diff);
            chan_in = chan_ff + 1'b1;
            if (chan_ff != 2'd0) begin
               error_sum_in = err_add[ERR_W] ? '1 : err_add[ERR_W-1:0];
            end
         end
         ST_CHECK: begin
            res_psnr_in    = '0;
            res_perfect_in = 1'b0;
            res_none_in    = 1'b0;
            if (!seen_valid_ff) begin
               res_none_in = 1'b1;
            end else if (error_sum_ff == '0) begin
               res_psnr_in    = '1;
               res_perfect_in = 1'b1;
            end
            pass_in = 1'b0;
         end
         ST_NUM: begin
            mul_a = MUL_W'(PEAK_SQ_X3);
            mul_b = MUL_W'(pixel_count_ff);
         end
         ST_LOAD: begin
            // First pass takes the numerator, second pass the error sum.
            x_in     = pass_ff ? error_sum_ff : product[ERR_W-1:0];
            shift_in = '0;
         end
         ST_NORM: begin
            // Left-align the operand one bit per cycle, counting the shifts.
            if (x_ff[ERR_W-1]) begin
               m_in    = x_ff[ERR_W-1 -: MUL_W];
               frac_in = '0;
               bit_in  = '0;
            end else begin
               x_in     = {x_ff[ERR_W-2:0], 1'b0};
               shift_in = shift_ff + 1'b1;
            end
         end
         ST_LOG_MUL: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         ST_LOG_UPD: begin
            frac_in = frac_next;
            bit_in  = bit_ff + 1'b1;
            m_in    = frac_bit ? sq_top[MUL_W:1] : sq_top[MUL_W-1:0];
            if ((bit_ff == BIT_CNT_W'(FRAC_BITS - 1)) && !pass_ff) begin
               la_in   = {exp_cur, frac_next};
               pass_in = 1'b1;
            end
         end
         ST_COMPARE: begin
            // A ratio of one or less reports zero with both flags clear.
            res_psnr_in    = '0;
            res_perfect_in = 1'b0;
            res_none_in    = 1'b0;
            l_in           = la_ff - lb;
         end
         ST_SCALE_LO: begin
            mul_a = MUL_W'(l_ff);
            mul_b = MUL_W'(K_LO);
         end
         ST_SCALE_HI: begin
            mul_a  = MUL_W'(l_ff);
            mul_b  = MUL_W'(K_HI);
            acc_in = ACC_W'(product[PART_W-1:0]) + ROUND_TERM;
         end
         ST_SCALE_SUM: begin
            res_psnr_in = q_raw[PSNR_W] ? '1 : q_raw[PSNR_W-1:0];
         end
         ST_EMIT: begin
            // Hand the result to the output register and clear the frame.
            if (emit_load) begin
               rsp_tvalid_in  = 1'b1;
               rsp_psnr_in    = res_psnr_ff;
               rsp_flags_in   = {res_none_ff, res_perfect_ff};
               error_sum_in   = '0;
               pixel_count_in = '0;
               seen_valid_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Register update.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mask_enable_ff <= 1'b0;
         error_sum_ff   <= '0;
         pixel_count_ff <= '0;
         seen_valid_ff  <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mask_enable_ff <= mask_enable_in;
         error_sum_ff   <= error_sum_in;
         pixel_count_ff <= pixel_count_in;
         seen_valid_ff  <= seen_valid_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
      diff_ff        <= diff_in;
      last_ff        <= last_in;
      chan_ff        <= chan_in;
      pass_ff        <= pass_in;
      x_ff           <= x_in;
      shift_ff       <= shift_in;
      m_ff           <= m_in;
      frac_ff        <= frac_in;
      bit_ff         <= bit_in;
      la_ff          <= la_in;
      l_ff           <= l_in;
      acc_ff         <= acc_in;
      res_psnr_ff    <= res_psnr_in;
      res_perfect_ff <= res_perfect_in;
      res_none_ff    <= res_none_in;
      rsp_psnr_ff    <= rsp_psnr_in;
      rsp_flags_ff   <= rsp_flags_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_psnr_ff;
   assign rsp_tuser  = rsp_flags_ff;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Masked RGB PSNR core testbench
// Streams pixel pairs into the core with random gaps on both channels and
// checks every frame result against a fixed-point predictor kept in step with
// each accepted pixel. Directed frames cover the flag cases, the unit ratio
// and mask changes; random frames of mixed length, content and masking follow.
// ----------------------------------------------------------------------------
module testbench;
   import mrp_pkg::*;

   // Cycles to let the core settle after its last result (longest frame end).
   localparam int SETTLE_CYCLES  = 200;
   // Cycles without any accepted transaction before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 4000;
   // Number of random pixels to stream.
   localparam int RANDOM_PIXELS  = 1650;
   // Idle chance in percent on each side.
   localparam int IDLE_PCT       = 16;

   localparam logic [63:0] ERR_MAX = (64'd1 << ERR_W) - 64'd1;

   // Kinds of pixel content for random frames.
   typedef enum int {
      CONTENT_RANDOM,
      CONTENT_NEAR,
      CONTENT_EQUAL,
      CONTENT_EXTREME
   } content_kind_type;

   // One frame result as carried on the result stream.
   typedef struct packed {
      logic [15:0] psnr;
      logic        perfect;
      logic        none;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Predictor state: frame accumulators and the mask register copy.
   logic [63:0] frame_error;
   logic [63:0] frame_pixels;
   logic        frame_used;
   logic        mask_copy;

   frame_result_type expected_frames[$];
   int          error_count  = 0;
   int          pixels_sent  = 0;
   int          stall_cycles = 0;
   bit          quiet        = 1'b0;

   masked_rgb_psnr_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Squared difference of one channel.
   function automatic logic [16:0] channel_sq_error(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return 17'(d) * 17'(d);
   endfunction

   // Base-2 logarithm in Q24: leading-one position, then 24 squaring steps.
   function automatic logic [63:0] log2_fixed(input logic [63:0] x);
      int unsigned lead;
      logic [63:0] m;
      logic [23:0] frac;
      lead = 0;
      frac = '0;
      if (x == 64'd0) begin
         return 64'd0;
      end
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            lead = i;
         end
      end
      m = (lead >= 31) ? (x >> (lead - 31)) : (x << (31 - lead));
      repeat (FRAC_BITS) begin
         m = (m * m) >> 31;
         frac = {frac[22:0], 1'b0};
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(lead) << FRAC_BITS) | 64'(frac);
   endfunction

   // PSNR in Q8.8 dB from pixel count and squared error sum.
   function automatic logic [15:0] predict_psnr_q8(input logic [63:0] n, input logic [63:0] ssd);
      logic [63:0] la, lb, l, ip, fp, v, q;
      la = log2_fixed(64'(PEAK_SQ_X3) * n);
      lb = log2_fixed(ssd);
      if (la <= lb) begin
         return 16'd0;
      end
      l  = la - lb;
      ip = l >> FRAC_BITS;
      fp = l & ((64'd1 << FRAC_BITS) - 64'd1);
      v  = ip * 64'(K_Q28) + ((fp * 64'(K_Q28)) >> FRAC_BITS);
      q  = (v + (64'd1 << 27)) >> 28;
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   // Result sink readiness, with random stalls outside the quiet stretch.
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // Follow every accepted transaction: update the predictor and check results.
   always @(posedge clock) begin : scoreboard
      logic [63:0] sum;
      logic [7:0]  fr, fg, fb, sr, sg, sb;
      frame_result_type expected;
      frame_result_type actual;
      if (reset) begin
         frame_error  = '0;
         frame_pixels = '0;
         frame_used   = 1'b0;
         mask_copy    = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mask_copy = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            actual = '{psnr: rsp_tdata, perfect: rsp_tuser[0], none: rsp_tuser[1]};
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d/%0b/%0b", $time,
                        actual.psnr, actual.perfect, actual.none);
               error_count++;
            end else begin
               expected = expected_frames.pop_front();
               if (actual.psnr !== expected.psnr) begin
                  $display("%0t: psnr_db_q8 mismatch, expected %0d, actual %0d", $time,
                           expected.psnr, actual.psnr);
                  error_count++;
               end
               if (actual.perfect !== expected.perfect) begin
                  $display("%0t: perfect_match mismatch, expected %0b, actual %0b", $time,
                           expected.perfect, actual.perfect);
                  error_count++;
               end
               if (actual.none !== expected.none) begin
                  $display("%0t: no_valid_pixels mismatch, expected %0b, actual %0b", $time,
                           expected.none, actual.none);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            {sb, sg, sr, fb, fg, fr} = req_tdata;
            if (!mask_copy || req_tuser) begin
               sum = frame_error + 64'(channel_sq_error(fr, sr))
                     + 64'(channel_sq_error(fg, sg)) + 64'(channel_sq_error(fb, sb));
               frame_error = (sum > ERR_MAX) ? ERR_MAX : sum;
               frame_used  = 1'b1;
            end
            if (frame_pixels < 64'(MAX_PIXELS)) begin
               frame_pixels++;
            end
            if (req_tlast) begin
               if (!frame_used) begin
                  expected = '{psnr: 16'd0, perfect: 1'b0, none: 1'b1};
               end else if (frame_error == 64'd0) begin
                  expected = '{psnr: 16'hFFFF, perfect: 1'b1, none: 1'b0};
               end else begin
                  expected = '{psnr: predict_psnr_q8(frame_pixels, frame_error),
                               perfect: 1'b0, none: 1'b0};
               end
               expected_frames.push_back(expected);
               frame_error  = '0;
               frame_pixels = '0;
               frame_used   = 1'b0;
            end
         end
      end
   end

   // Count cycles in which no transaction of any channel is accepted.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               expected_frames.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Send one pixel pair and return at the edge where it is accepted.
   task automatic send_pixel(input logic [7:0] fr, input logic [7:0] fg, input logic [7:0] fb,
                             input logic [7:0] sr, input logic [7:0] sg, input logic [7:0] sb,
                             input logic valid, input logic last);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {sb, sg, sr, fb, fg, fr};
      req_tuser  <= valid;
      req_tlast  <= last;
      do begin
         @(posedge clock);
      end while (!req_tready);
      pixels_sent++;
   endtask

   // Hold off the sender until every frame result is in and the core is quiet.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the mask register while the core is idle.
   task automatic write_mask(input logic value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Second-image channel a few steps away from the first, kept in range.
   function automatic logic [7:0] nearby_level(input logic [7:0] a);
      int v;
      v = int'(a) + int'($urandom_range(6)) - 3;
      if (v < 0) begin
         v = 0;
      end else if (v > 255) begin
         v = 255;
      end
      return v[7:0];
   endfunction

   // One frame of pixels with the given length, valid share and content kind.
   task automatic send_random_frame(input int length, input int valid_pct,
                                    input content_kind_type kind);
      logic [7:0] a[3];
      logic [7:0] b[3];
      logic       valid;
      for (int i = 0; i < length; i++) begin
         for (int c = 0; c < 3; c++) begin
            a[c] = 8'($urandom_range(255));
            case (kind)
               CONTENT_NEAR: begin
                  b[c] = nearby_level(a[c]);
               end
               CONTENT_EQUAL: begin
                  b[c] = a[c];
               end
               CONTENT_EXTREME: begin
                  a[c] = $urandom_range(1) ? 8'hFF : 8'h00;
                  b[c] = $urandom_range(3) == 0 ? a[c] : ~a[c];
               end
               default: begin
                  b[c] = 8'($urandom_range(255));
               end
            endcase
         end
         valid = ($urandom_range(99) < valid_pct);
         send_pixel(a[0], a[1], a[2], b[0], b[1], b[2], valid, i == length - 1);
      end
   endtask

   // Identical images: saturated output with the perfect-match flag.
   task automatic test_perfect_match();
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
      send_pixel(8'd18, 8'd200, 8'd77, 8'd18, 8'd200, 8'd77, 1'b0, 1'b1);
   endtask

   // Full-scale difference on every channel gives a ratio of exactly one.
   task automatic test_unit_ratio();
      send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1);
   endtask

   // Smallest nonzero error, the highest unsaturated PSNR for a short frame.
   task automatic test_small_error();
      send_pixel(8'd100, 8'd100, 8'd100, 8'd101, 8'd100, 8'd100, 1'b1, 1'b0);
      send_pixel(8'd7, 8'd8, 8'd9, 8'd7, 8'd8, 8'd9, 1'b1, 1'b0);
      send_pixel(8'd128, 8'd64, 8'd32, 8'd128, 8'd64, 8'd32, 1'b1, 1'b0);
      send_pixel(8'd1, 8'd254, 8'd85, 8'd1, 8'd254, 8'd85, 1'b1, 1'b1);
   endtask

   // With masking off, pixels marked invalid still count toward the error.
   task automatic test_unmasked_invalid();
      send_pixel(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 1'b0, 1'b0);
      send_pixel(8'd170, 8'd85, 8'd240, 8'd15, 8'd90, 8'd200, 1'b0, 1'b1);
   endtask

   // With masking on: a frame with no used pixel, and a masked last pixel.
   task automatic test_masked_frames();
      write_mask(1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b0);
      send_pixel(8'd33, 8'd66, 8'd99, 8'd44, 8'd77, 8'd11, 1'b0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
      send_pixel(8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 1'b1, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
      send_pixel(8'd90, 8'd90, 8'd90, 8'd91, 8'd92, 8'd93, 1'b0, 1'b1);
   endtask

   // Mask change in the middle of a frame applies from the next pixel on.
   task automatic test_mask_change_mid_frame();
      send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
      write_mask(1'b0);
      send_pixel(8'd50, 8'd60, 8'd70, 8'd52, 8'd60, 8'd70, 1'b0, 1'b1);
   endtask

   // Random frames: mostly short, some long, mixed content and masking.
   task automatic test_random_frames();
      int          start;
      int          done;
      int          frames;
      int          length;
      int          valid_pct;
      int          pick;
      content_kind_type kind;
      start  = pixels_sent;
      frames = 0;
      done   = 0;
      while (done < RANDOM_PIXELS) begin
         quiet = (done >= 600) && (done < 900);
         if (frames % 6 == 5) begin
            write_mask(1'($urandom_range(1)));
         end
         pick = $urandom_range(99);
         if (pick < 2) begin
            length = $urandom_range(600, 300);
         end else if (pick < 10) begin
            length = $urandom_range(120, 25);
         end else begin
            length = $urandom_range(24, 1);
         end
         // Keep the total number of random pixels at the planned count.
         if (length > RANDOM_PIXELS - done) begin
            length = RANDOM_PIXELS - done;
         end
         pick = $urandom_range(99);
         valid_pct = (pick < 40) ? 100 : (pick < 70) ? 85 : (pick < 90) ? 50 : 0;
         pick = $urandom_range(99);
         kind = (pick < 40) ? CONTENT_RANDOM : (pick < 75) ? CONTENT_NEAR :
                (pick < 90) ? CONTENT_EQUAL : CONTENT_EXTREME;
         send_random_frame(length, valid_pct, kind);
         frames++;
         done = pixels_sent - start;
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_perfect_match();
      test_unit_ratio();
      test_small_error();
      test_unmasked_invalid();
      test_masked_frames();
      test_mask_change_mid_frame();
      test_random_frames();
      write_mask(1'b0);

      wait_for_results();
      if (expected_frames.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_frames.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
src/mrp_pkg.sv
src/mrp_mul.sv
src/masked_rgb_psnr_core.sv
test/testbench.sv
